// ===== sv/green_chroma_histogram_threshold_assert.svh =====
// Assertion macros shared by the green chroma histogram RTL.
// Each macro expands to one labelled concurrent assertion on the given clock.
`ifndef GREEN_CHROMA_HISTOGRAM_THRESHOLD_ASSERT_SVH
`define GREEN_CHROMA_HISTOGRAM_THRESHOLD_ASSERT_SVH

// Checked only while out of reset.
`define GCH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define GCH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gch_pkg.sv =====
// Shared types and constants for the green chroma histogram threshold block.
// No dependencies.
package gch_pkg;

  localparam int BIN_COUNT_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_LEARN    = 2'd0,
    CMD_CLOSE    = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] chroma;
    logic       is_green;
    logic [7:0] threshold;
  } out_payload_t;

  // Per-cycle control broadcast along the row of histogram cells.
  typedef struct packed {
    logic learn;   // bump the cell whose index matches the bin
    logic shift;   // every cell takes its right-hand neighbour's count
  } cell_ctrl_t;

endpackage

// ===== sv/gch_cell.sv =====
// One histogram bin: a saturating counter that can shift its count to the
// left-hand neighbour. Depends on gch_pkg.
module gch_cell #(
  parameter int BIN_COUNT  = gch_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = gch_pkg::COUNT_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gch_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(BIN_COUNT)-1:0] bin,
  input  logic [COUNT_BITS-1:0]        shift_in,
  output logic [COUNT_BITS-1:0]        count
);

  localparam int IDX_W = $clog2(BIN_COUNT);

  logic [COUNT_BITS-1:0] count_r;
  logic                  hit;

  assign hit   = ctrl.learn && (bin == IDX_W'(CELL_IDX)) && !(&count_r);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.shift) begin
      count_r <= shift_in;
    end else if (hit) begin
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

endmodule

// ===== sv/gch_div.sv =====
// Green chroma 255*g/(b+g+r) by restoring division, one quotient bit a cycle.
// Quotient never exceeds 255, so eight steps suffice. Depends on nothing.
module gch_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic       done,
  output logic [7:0] quotient
);

  logic [9:0]  sum;
  logic [15:0] num;
  logic [15:0] rem_r;
  logic [16:0] den_r;
  logic [7:0]  q_r;
  logic [2:0]  cnt_r;
  logic        active_r;
  logic        done_r;
  logic        zero_r;
  logic        ge;

  assign sum = 10'(blue) + 10'(green) + 10'(red);
  assign num = {green, 8'h00} - 16'(green);
  assign ge  = {1'b0, rem_r} >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
      end else if (active_r && cnt_r == 3'd0) begin
        active_r <= 1'b0;
        done_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= {sum, 7'b0};
      q_r    <= '0;
      cnt_r  <= 3'd7;
      zero_r <= (sum == '0);
    end else if (active_r) begin
      if (ge) begin
        rem_r <= 16'({1'b0, rem_r} - den_r);
      end
      den_r <= den_r >> 1;
      q_r   <= {q_r[6:0], ge};
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // black pixel: sum of zero gives chroma zero
  assign quotient = zero_r ? 8'd0 : q_r;
  assign done     = done_r;

endmodule

// ===== sv/green_chroma_histogram_threshold.sv =====
// Green chroma histogram threshold: top level.
// Learn, classify and unused requests wait on the bit-serial divider (8 steps). Close
// requests sweep the row of bin cells: it shifts its counts past the peak comparator
// once, clearing itself. One request in flight: the next is taken once the result is
// registered on the output, and an output stall holds it off. Synchronous reset clears
// counts.
module green_chroma_histogram_threshold #(
  parameter int BIN_COUNT  = gch_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = gch_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gch_pkg::in_payload_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gch_pkg::out_payload_t out_data
);

  `include "green_chroma_histogram_threshold_assert.svh"

  localparam int IDX_W = $clog2(BIN_COUNT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            cmd_r;
  logic [7:0]            thr_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  gch_pkg::out_payload_t res_r;
  gch_pkg::out_payload_t out_data_r;
  logic                  out_valid_r;

  logic                  accept;
  logic                  out_free;
  logic                  sweep_last;
  logic                  div_done;
  logic [7:0]            div_q;
  logic [16:0]           bin_prod;
  logic [IDX_W-1:0]      learn_bin;
  gch_pkg::cell_ctrl_t   cell_ctrl;

  logic [COUNT_BITS-1:0] cnt [BIN_COUNT];
  logic [7:0]            thr_tab [BIN_COUNT];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  gch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && in_data.command != gch_pkg::CMD_CLOSE),
    .blue     (in_data.blue),
    .green    (in_data.green),
    .red      (in_data.red),
    .done     (div_done),
    .quotient (div_q)
  );

  // bin = chroma * BIN_COUNT / 256
  assign bin_prod  = 17'(div_q) * 17'(BIN_COUNT);
  assign learn_bin = bin_prod[8 +: IDX_W];

  assign cell_ctrl.learn = div_done && (cmd_r == gch_pkg::CMD_LEARN);
  assign cell_ctrl.shift = (state_r == S_SWEEP);

  for (genvar gi = 0; gi < BIN_COUNT; gi++) begin : g_cell
    logic [COUNT_BITS-1:0] shift_in;

    if (gi == BIN_COUNT - 1) begin : g_tail
      assign shift_in = '0;   // zeros enter at the far end, clearing the row
    end else begin : g_mid
      assign shift_in = cnt[gi+1];
    end

    assign thr_tab[gi] = 8'((gi * 256) / BIN_COUNT);

    gch_cell #(
      .BIN_COUNT  (BIN_COUNT),
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .bin      (learn_bin),
      .shift_in (shift_in),
      .count    (cnt[gi])
    );
  end

  // peak search at the head of the row; strict compare keeps the first peak
  always_comb begin
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    if (cnt[0] > best_cnt_r) begin
      best_idx_nxt = idx_r;
      best_cnt_nxt = cnt[0];
    end
  end

  assign sweep_last = (idx_r == IDX_W'(BIN_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.command == gch_pkg::CMD_CLOSE) ? S_SWEEP : S_CALC;
        end
      end
      S_CALC: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_SWEEP: begin
        if (sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        idx_r <= '0;
      end else if (state_r == S_SWEEP) begin
        idx_r <= sweep_last ? '0 : idx_r + IDX_W'(1);
        if (sweep_last) thr_r <= thr_tab[best_idx_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_data.command;
      best_idx_r <= '0;
      best_cnt_r <= '0;
    end
    if (state_r == S_SWEEP) begin
      best_idx_r <= best_idx_nxt;
      best_cnt_r <= best_cnt_nxt;
      if (sweep_last) begin
        res_r.chroma    <= 8'd0;
        res_r.is_green  <= 1'b0;
        res_r.threshold <= thr_tab[best_idx_nxt];
      end
    end
    if (div_done) begin
      res_r.chroma    <= div_q;
      res_r.is_green  <= (cmd_r == gch_pkg::CMD_CLASSIFY) && (div_q > thr_r);
      res_r.threshold <= thr_r;
    end
    if (state_r == S_DONE && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GCH_ASSERT(a_close_starts_sweep, clk, rst_n, (accept && in_data.command == gch_pkg::CMD_CLOSE) |=> (state_r == S_SWEEP), "close request did not start the bin sweep")
  `GCH_ASSERT(a_idle_idx_zero, clk, rst_n, (state_r == S_IDLE) |-> (idx_r == '0), "sweep index not parked while idle")
  `GCH_ASSERT(a_div_done_in_calc, clk, rst_n, div_done |-> (state_r == S_CALC), "divider finished outside the calc state")
  `GCH_ASSERT(a_green_above_thr, clk, rst_n, out_valid_r |-> (!out_data_r.is_green || (out_data_r.chroma > out_data_r.threshold)), "green flag without chroma above threshold")

endmodule

// ===== dv/tb_green_chroma_histogram_threshold.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for green_chroma_histogram_threshold: directed and random requests,
// each result checked against an in-bench model of the chroma histogram and threshold.
// Depends on gch_pkg and the green_chroma_histogram_threshold RTL only.
module tb_green_chroma_histogram_threshold;

  localparam int BINS = gch_pkg::BIN_COUNT_DEF;
  localparam int TALLY_MAX = (1 << gch_pkg::COUNT_BITS_DEF) - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 2 * BINS + 20;
  localparam int PRINT_CAP = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gch_pkg::in_payload_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gch_pkg::out_payload_t out_data;

  logic [gch_pkg::COUNT_BITS_DEF-1:0] bin_tally [BINS];
  logic [7:0] green_level;
  gch_pkg::out_payload_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  green_chroma_histogram_threshold i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_tally();
    for (int i = 0; i < BINS; i++) bin_tally[i] = '0;
  endfunction

  function automatic logic [7:0] chroma_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned sum;
    int unsigned gi;
    sum = int'(b) + int'(g) + int'(r);
    gi = g;
    if (sum == 0) return 8'd0;
    return 8'((255 * gi) / sum);
  endfunction

  // Updates the histogram and threshold, returns the result the request should give.
  function automatic gch_pkg::out_payload_t predict_result(gch_pkg::in_payload_t req);
    gch_pkg::out_payload_t res;
    logic [7:0] c;
    int unsigned bin;
    int unsigned best;
    int unsigned best_count;
    c = chroma_of(req.blue, req.green, req.red);
    res.is_green = 1'b0;
    case (req.command)
      gch_pkg::CMD_LEARN: begin
        bin = (int'(c) * BINS) / 256;
        if (bin >= BINS) bin = BINS - 1;
        if (bin_tally[bin] != TALLY_MAX) bin_tally[bin] = bin_tally[bin] + 1'b1;
      end
      gch_pkg::CMD_CLOSE: begin
        best = 0;
        best_count = 0;
        for (int i = 0; i < BINS; i++) begin
          if (bin_tally[i] > best_count) begin
            best_count = bin_tally[i];
            best = i;
          end
        end
        green_level = 8'((best * 256) / BINS);
        clear_tally();
        c = 8'd0;
      end
      gch_pkg::CMD_CLASSIFY: res.is_green = (c > green_level);
      default: ;
    endcase
    res.chroma = c;
    res.threshold = green_level;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < PRINT_CAP)
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_result(gch_pkg::out_payload_t got);
    gch_pkg::out_payload_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding", got, 0);
    end else begin
      want = pending_results.pop_front();
      if (got.chroma !== want.chroma) report_mismatch("chroma", got.chroma, want.chroma);
      if (got.is_green !== want.is_green)
        report_mismatch("is_green", got.is_green, want.is_green);
      if (got.threshold !== want.threshold)
        report_mismatch("threshold", got.threshold, want.threshold);
    end
  endtask

  // Result side: accept and check, with random stall bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    gch_pkg::in_payload_t req;
    req = '{command: cmd, blue: b, green: g, red: r};
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_result(req));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding request has produced its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(logic [1:0] cmd);
    logic [7:0] b, g, r;
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
      1: begin
        g = $urandom_range(128, 255);
        b = $urandom_range(0, g / 2);
        r = $urandom_range(0, g / 2);
      end
      2: begin
        // near-black, sum often zero
        b = $urandom_range(0, 2);
        g = $urandom_range(0, 2);
        r = $urandom_range(0, 2);
      end
      default: begin
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        r = b;
      end
    endcase
    send_request(cmd, b, g, r);
  endtask

  task automatic test_empty_close();
    send_request(gch_pkg::CMD_CLOSE, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_CLASSIFY, 8'd0, 8'd255, 8'd0);
    send_request(CMD_UNUSED, 8'd10, 8'd200, 8'd30);
  endtask

  task automatic test_pixel_extremes();
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd255, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd255, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd0, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd0, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd3, 8'd255, 8'd4);
    send_request(gch_pkg::CMD_CLOSE, 8'd255, 8'd255, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd255, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd255, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_CLOSE, 8'd0, 8'd0, 8'd0);
    // chroma equal to the threshold is not green
    send_request(gch_pkg::CMD_CLASSIFY, 8'd3, 8'd255, 8'd4);
    send_request(gch_pkg::CMD_CLASSIFY, 8'd0, 8'd255, 8'd0);
    send_request(gch_pkg::CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_peak_tie();
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd255, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd100, 8'd20, 8'd135);
    send_request(gch_pkg::CMD_CLOSE, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd255, 8'd255);
    send_request(gch_pkg::CMD_LEARN, 8'd100, 8'd20, 8'd135);
    send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd255, 8'd255);
    send_request(gch_pkg::CMD_CLOSE, 8'd0, 8'd0, 8'd0);
  endtask

  // Load the top bin well past bin 0; the close must pick the top bin.
  task automatic test_heavy_bin();
    quiet = 1'b1;
    repeat (10) send_request(gch_pkg::CMD_LEARN, 8'd255, 8'd0, 8'd0);
    repeat (100)
      send_request(gch_pkg::CMD_LEARN, 8'($urandom_range(0, 1)), 8'd255,
                   8'($urandom_range(0, 1)));
    send_request(gch_pkg::CMD_CLOSE, 8'd0, 8'd0, 8'd0);
    send_request(gch_pkg::CMD_CLASSIFY, 8'd0, 8'd255, 8'd0);
    quiet = 1'b0;
  endtask

  task automatic test_random_frames(int goal);
    int sent;
    int frame;
    int learn_len;
    int classify_len;
    sent = 0;
    frame = 0;
    while (sent < goal) begin
      quiet = (sent > goal - 150) || ($urandom_range(0, 7) == 0);
      learn_len = $urandom_range(0, 40);
      classify_len = $urandom_range(1, 30);
      for (int i = 0; i < learn_len; i++)
        send_pixel(($urandom_range(0, 15) == 0) ? CMD_UNUSED : gch_pkg::CMD_LEARN);
      send_pixel(gch_pkg::CMD_CLOSE);
      for (int i = 0; i < classify_len; i++)
        send_pixel(($urandom_range(0, 15) == 0) ? CMD_UNUSED : gch_pkg::CMD_CLASSIFY);
      sent += learn_len + classify_len + 1;
      frame++;
      if (frame % 10 == 5) drain_results();
    end
    quiet = 1'b1;
  endtask

  initial begin
    clear_tally();
    green_level = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_close();
    test_pixel_extremes();
    test_peak_tie();
    drain_results();
    test_heavy_bin();
    drain_results();
    test_random_frames(900);
    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/gch_pkg.sv
sv/gch_cell.sv
sv/gch_div.sv
sv/green_chroma_histogram_threshold.sv
dv/tb_green_chroma_histogram_threshold.sv
